// ===== design/pjwhm_pkg.sv =====
// ----------------------------------------------------------------------------
// pjwhm_pkg
// Shared widths and constants for the string hash bucket unit.
// ----------------------------------------------------------------------------
package pjwhm_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HashW   = 28;
  localparam int unsigned BucketW = 31;
  localparam int unsigned SumW    = 32;

  // hash step constants
  localparam int unsigned StepShift = 4;
  localparam int unsigned TopW      = SumW - HashW;

  // reset value of the bucket count register
  localparam logic [BucketW-1:0] BucketReset = BucketW'(1024);

  // default depth of the queue between hash front and modulo back
  localparam int unsigned QueueDepthDefault = 2;

  // one hash step: shift, add sign-extended byte, fold top nibble back in
  function automatic logic [HashW-1:0] absorb(input logic [HashW-1:0] h,
                                              input logic [ByteW-1:0] b);
    logic [SumW-1:0] sum;
    logic [TopW-1:0] top;
    sum = {h, StepShift'(0)} + {{(SumW-ByteW){b[ByteW-1]}}, b};
    top = sum[SumW-1 -: TopW];
    return sum[HashW-1:0] ^ {(HashW-TopW-StepShift)'(0), top, StepShift'(0)};
  endfunction

endpackage

// ===== design/pjwhm_fifo.sv =====
// ----------------------------------------------------------------------------
// pjwhm_fifo
// Small register queue carrying finished key hashes from front to back.
// ----------------------------------------------------------------------------
module pjwhm_fifo #(
  parameter int unsigned Depth = pjwhm_pkg::QueueDepthDefault,
  parameter int unsigned Width = pjwhm_pkg::HashW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // pointer wrap at the configured depth
  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      count <= count + CntW'(1);
      else if (!do_push && do_pop) count <= count - CntW'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth)) else $error("queue count beyond depth");

  a_count_inc: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + CntW'(1)))
    else $error("queue count missed a push");

endmodule

// ===== design/pjwhm_front.sv =====
// ----------------------------------------------------------------------------
// pjwhm_front
// Absorbs key bytes into the running hash and queues the hash of each key.
// ----------------------------------------------------------------------------
module pjwhm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pjwhm_pkg::ByteW-1:0]   key_byte,
  input  logic                          last_byte,
  output logic                          q_push,
  output logic [pjwhm_pkg::HashW-1:0]   q_data,
  input  logic                          q_full
);

  logic [pjwhm_pkg::HashW-1:0] running_hash;
  logic [pjwhm_pkg::HashW-1:0] running_hash_next;
  logic                        accept;

  // a key byte waits while no queue slot is free for a possible key end
  assign full   = q_full;
  assign accept = push && !q_full;

  assign running_hash_next = pjwhm_pkg::absorb(running_hash, key_byte);
  assign q_push            = accept && last_byte;
  assign q_data            = running_hash_next;

  // running hash, cleared at the end of each key
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
    end else if (accept) begin
      running_hash <= last_byte ? '0 : running_hash_next;
    end
  end

endmodule

// ===== design/pjwhm_mod.sv =====
// ----------------------------------------------------------------------------
// pjwhm_mod
// Restoring remainder unit, one dividend bit a cycle, with an output word
// register.
// ----------------------------------------------------------------------------
module pjwhm_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pjwhm_pkg::BucketW-1:0] divisor,
  input  logic                          q_empty,
  input  logic [pjwhm_pkg::HashW-1:0]   q_data,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [pjwhm_pkg::HashW-1:0]   bucket_index
);

  localparam int unsigned Steps = pjwhm_pkg::HashW;
  localparam int unsigned CntW  = $clog2(Steps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  state_t                        state;
  logic [CntW-1:0]               cnt;
  logic [pjwhm_pkg::HashW-1:0]   dvd;
  logic [pjwhm_pkg::HashW-1:0]   rem;
  logic [pjwhm_pkg::HashW-1:0]   rem_next;
  logic [pjwhm_pkg::BucketW-1:0] trial;
  logic                          out_valid;
  logic                          out_free;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // one restoring step; a zero divisor leaves the hash unreduced
  always_comb begin
    trial    = {(pjwhm_pkg::BucketW-pjwhm_pkg::HashW-1)'(0),
                rem, dvd[pjwhm_pkg::HashW-1]};
    rem_next = trial[pjwhm_pkg::HashW-1:0];
    if (divisor != '0 && trial >= divisor) begin
      rem_next = pjwhm_pkg::HashW'(trial - divisor);
    end
  end

  // sequencer and output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_HOLD) && out_free) out_valid <= 1'b1;
      else if (pop && out_valid)          out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            dvd   <= q_data;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          rem <= rem_next;
          dvd <= {dvd[pjwhm_pkg::HashW-2:0], 1'b0};
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(Steps - 1)) state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            bucket_index <= rem;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pop) else $error("queue read while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= CntW'(Steps - 1)))
    else $error("step count overran");

endmodule

// ===== design/pjw_string_hash_mod_unit.sv =====
// ----------------------------------------------------------------------------
// pjw_string_hash_mod_unit
// Byte-serial PJW/ELF string hash reduced modulo a bucket count.
//
//   channel   signals                          handshake
//   key in    key_byte, last_byte              push / full
//   result    bucket_index                     pop / empty
//   config    bucket_count                     cfg_valid / cfg_ready
//
// Key bytes are taken one a cycle while the hash queue has room.
// Each key end is reduced in the remainder unit (load, one dividend bit a
// cycle over 28 steps, then write-out); keys are queued in front of it.
// Reset clears the running hash, the queue and the result word; bucket_count
// returns to 1024. A result word waiting on pop stalls the remainder unit,
// which then fills the queue and raises full.
// ----------------------------------------------------------------------------
module pjw_string_hash_mod_unit #(
  parameter int unsigned QueueDepth = pjwhm_pkg::QueueDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pjwhm_pkg::ByteW-1:0]   key_byte,
  input  logic                          last_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [pjwhm_pkg::HashW-1:0]   bucket_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pjwhm_pkg::BucketW-1:0] bucket_count
);

  logic [pjwhm_pkg::BucketW-1:0] divisor;
  logic                          q_push;
  logic [pjwhm_pkg::HashW-1:0]   q_wdata;
  logic                          q_full;
  logic                          q_pop;
  logic [pjwhm_pkg::HashW-1:0]   q_rdata;
  logic                          q_empty;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= pjwhm_pkg::BucketReset;
    end else if (cfg_valid && cfg_ready) begin
      divisor <= bucket_count;
    end
  end

  // hash front
  pjwhm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .key_byte  (key_byte),
    .last_byte (last_byte),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  // queue of finished hashes
  pjwhm_fifo #(
    .Depth (QueueDepth),
    .Width (pjwhm_pkg::HashW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // remainder back end
  pjwhm_mod u_mod (
    .clk          (clk),
    .rst          (rst),
    .divisor      (divisor),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .bucket_index (bucket_index)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the string hash bucket unit. Keys are streamed in a
// byte at a time, a predictor folds each accepted byte into its own copy of
// the running hash, and every bucket index word that is popped is compared
// in order against the predicted one. The bucket count is reprogrammed
// between phases while the block is idle, covering zero, one and the
// 31-bit maximum. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [pjwhm_pkg::ByteW-1:0]   byte_t;
  typedef logic [pjwhm_pkg::HashW-1:0]   hash_t;
  typedef logic [pjwhm_pkg::BucketW-1:0] count_t;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned SettleCycles  = 64;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseBytes    = 170;

  // running hash and bucket index predictor with in-order index store
  class bucket_scoreboard;
    hash_t       running;
    count_t      divisor;
    hash_t       index_store[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned unreduced;

    function new();
      running    = '0;
      divisor    = pjwhm_pkg::BucketReset;
      mismatches = 0;
      checked    = 0;
      unreduced  = 0;
    endfunction

    function void set_divisor(count_t d);
      divisor = d;
    endfunction

    function int unsigned pending();
      return index_store.size();
    endfunction

    // fold one accepted key byte, predict an index on the final byte
    function void note_byte(byte_t b, logic last);
      logic [pjwhm_pkg::SumW-1:0] sum;
      logic [pjwhm_pkg::SumW-1:0] rem;
      hash_t                      h;
      sum = {running, 4'h0} +
            {{(pjwhm_pkg::SumW-pjwhm_pkg::ByteW){b[pjwhm_pkg::ByteW-1]}}, b};
      h = sum[pjwhm_pkg::HashW-1:0];
      // top nibble goes back in at bits 7..4 and is dropped from the top
      h[7:4] = h[7:4] ^ sum[pjwhm_pkg::SumW-1:pjwhm_pkg::HashW];
      running = h;
      if (last) begin
        if (divisor == '0) begin
          index_store.push_back(h);
          unreduced++;
        end else begin
          rem = pjwhm_pkg::SumW'(h) % pjwhm_pkg::SumW'(divisor);
          index_store.push_back(rem[pjwhm_pkg::HashW-1:0]);
        end
        running = '0;
      end
    endfunction

    // compare a popped index word against the oldest prediction
    function void check_index(hash_t got);
      hash_t want;
      if (index_store.size() == 0) begin
        $display("%0t: unexpected bucket index, expected none, actual %0d", $time, got);
        mismatches++;
      end else begin
        want = index_store.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                   $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  byte_t  key_byte;
  logic   last_byte;
  logic   empty;
  logic   pop;
  hash_t  bucket_index;
  logic   cfg_valid;
  logic   cfg_ready;
  count_t bucket_count;

  bucket_scoreboard sb;
  int unsigned      cycles;
  int unsigned      keys_sent;
  int unsigned      bytes_sent;
  int unsigned      counts_written;
  bit               send_quiet;
  bit               take_quiet;

  pjw_string_hash_mod_unit dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .key_byte     (key_byte),
    .last_byte    (last_byte),
    .empty        (empty),
    .pop          (pop),
    .bucket_index (bucket_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .bucket_count (bucket_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned roll;
    roll = $urandom_range(99);
    if (quiet || roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // push one key byte and wait for it to be taken
  task automatic send_byte(input byte_t b, input logic last);
    int unsigned gap;
    gap = pick_gap(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    key_byte  <= b;
    last_byte <= last;
    do @(posedge clk); while (full);
    sb.note_byte(b, last);
    bytes_sent++;
    if (last) keys_sent++;
  endtask

  // one key of random length and content
  task automatic send_random_key();
    int unsigned len;
    int unsigned roll;
    byte_t       b;
    roll = $urandom_range(99);
    if (roll < 70) len = $urandom_range(1, 6);
    else if (roll < 95) len = $urandom_range(7, 16);
    else len = $urandom_range(17, 48);
    send_quiet = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(6) == 0) begin
        case ($urandom_range(3))
          0: b = 8'h00;
          1: b = 8'h7f;
          2: b = 8'h80;
          default: b = 8'hff;
        endcase
      end else begin
        b = byte_t'($urandom);
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // stop sending, let every index word come back, then let the block settle
  task automatic drain_and_settle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // program the bucket count while the block is idle
  task automatic write_bucket_count(input count_t value);
    @(negedge clk);
    cfg_valid    <= 1'b1;
    bucket_count <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_divisor(value);
    counts_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // bucket count plan, extremes first
  function automatic count_t divisor_for(int unsigned phase);
    case (phase)
      0: return count_t'(1);
      1: return '1;
      2: return '0;
      3: return count_t'(3);
      4: return count_t'(32'h1000_0000);
      5: return count_t'(32'h0fff_ffff);
      6: return count_t'($urandom_range(2, 4096));
      7: return count_t'($urandom);
      default: return pjwhm_pkg::BucketReset;
    endcase
  endfunction

  // result side: pop with random stalls, check each accepted word
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    take_quiet = 1'b0;
    pop        = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if ($urandom_range(199) == 0) take_quiet = ~take_quiet;
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (take_quiet) begin
        pop <= 1'b1;
      end else begin
        stall_left = pick_gap(1'b0);
        if (stall_left > 0) begin
          pop <= 1'b0;
          stall_left--;
        end else begin
          pop <= 1'b1;
        end
      end
      @(posedge clk);
      if (pop && !empty) sb.check_index(bucket_index);
    end
  end

  // stimulus
  initial begin
    int unsigned phase_start;
    rst            = 1'b1;
    push           = 1'b0;
    key_byte       = '0;
    last_byte      = 1'b0;
    cfg_valid      = 1'b0;
    bucket_count   = '0;
    send_quiet     = 1'b0;
    keys_sent      = 0;
    bytes_sent     = 0;
    counts_written = 0;
    sb             = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed keys under the reset bucket count
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b1);
    // zero bytes inside a key do not end it
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    // negative bytes repeatedly carry into the top nibble
    repeat (7) send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    // printable key long enough to fold several times
    for (int unsigned i = 0; i < 8; i++) send_byte(byte_t'(8'h41 + i), i == 7);
    drain_and_settle();

    // random keys, one phase per bucket count
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_bucket_count(divisor_for(p));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_random_key();
      drain_and_settle();
    end

    $display("covered %0d keys over %0d bytes, %0d bucket indices checked",
             keys_sent, bytes_sent, sb.checked);
    $display("%0d bucket counts programmed incl. zero, one and the 31-bit maximum; %0d %s",
             counts_written, sb.unreduced, "indices taken unreduced");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/pjwhm_pkg.sv
design/pjwhm_fifo.sv
design/pjwhm_front.sv
design/pjwhm_mod.sv
design/pjw_string_hash_mod_unit.sv
tb/testbench.sv
